FILE: rtl/hrdp_pkg.sv
// Shared types, codes and constants for the HID report descriptor parser.
package hrdp_pkg;

    // Default width of the running input and output bit offsets.
    localparam int unsigned OFFSET_BITS_DEFAULT = 16;

    // Depth of the item queue between the byte assembler and the executor.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Item types from the prefix byte.
    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;

    // Tag nibble that opens a long item.
    localparam logic [3:0] LONG_ITEM_TAG = 4'b1111;

    // Main item tags.
    localparam logic [7:0] MAIN_TAG_INPUT   = 8'd8;
    localparam logic [7:0] MAIN_TAG_OUTPUT  = 8'd9;
    localparam logic [7:0] MAIN_TAG_END_COL = 8'd12;

    // Global item tags.
    localparam logic [7:0] GLOBAL_TAG_PAGE  = 8'd0;
    localparam logic [7:0] GLOBAL_TAG_MIN   = 8'd1;
    localparam logic [7:0] GLOBAL_TAG_MAX   = 8'd2;
    localparam logic [7:0] GLOBAL_TAG_SIZE  = 8'd7;
    localparam logic [7:0] GLOBAL_TAG_ID    = 8'd8;
    localparam logic [7:0] GLOBAL_TAG_COUNT = 8'd9;

    // Event kinds on the result channel.
    localparam logic [2:0] EVENT_NONE    = 3'd0;
    localparam logic [2:0] EVENT_LOCAL   = 3'd1;
    localparam logic [2:0] EVENT_INPUT   = 3'd2;
    localparam logic [2:0] EVENT_OUTPUT  = 3'd3;
    localparam logic [2:0] EVENT_END_COL = 3'd4;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] desc_byte;
        logic       last_byte;
    } in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  item_tag;
        logic [31:0] item_value;
        logic [7:0]  rpt_id;
        logic [7:0]  report_size;
        logic [15:0] report_count;
        logic [15:0] field_offset;
        logic [15:0] usage_page;
        logic [31:0] logical_min;
        logic [31:0] logical_max;
        logic        descriptor_done;
    } out_t;

    // One assembled item, or an end-of-descriptor marker, in the queue.
    typedef struct packed {
        logic        has_item;
        logic [1:0]  item_type;
        logic [7:0]  item_tag;
        logic [31:0] item_value;
        logic        last;
    } item_t;

    // Data byte count for each short item size code.
    function automatic logic [7:0] short_len(input logic [1:0] code);
        logic [7:0] len;
        case (code)
            2'd0:    len = 8'd0;
            2'd1:    len = 8'd1;
            2'd2:    len = 8'd2;
            default: len = 8'd4;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/hid_report_descriptor_parser.sv
// Top level of the HID report descriptor parser.
//
// Feed the report descriptor one byte per input transaction, with last_byte set on
// the final byte. The block accepts one byte every clock cycle while its item queue
// has room; the front assembler holds no byte back on its own, and the
// executor retires one queued item per cycle, so the sustained rate is one byte per
// cycle with the result channel ready. A result transaction reaches the output from
// the byte that completes its item through a queue slot and then the result
// register. Results come out for local items, non-constant Input items and Output
// items with a nonzero report size, and End Collection items, each with a snapshot of
// the global state after the item. The last byte always yields a result with
// descriptor_done set, with kind none when it completes no reportable item; any
// unfinished item is dropped and all state returns to its reset value. The input
// and output bit offsets are OFFSET_BITS wide and saturate at their all-ones value;
// field_offset carries the low 16 bits.
module hid_report_descriptor_parser #(
    parameter int unsigned OFFSET_BITS = hrdp_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  hrdp_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output hrdp_pkg::out_t  m_data
);

    // Queue handshake between the assembler and the executor.
    logic             q_full;
    logic             q_not_empty;
    logic             q_push;
    logic             q_pop;
    hrdp_pkg::item_t  q_push_item;
    hrdp_pkg::item_t  q_head_item;

    // Assemble prefix, length, tag and data bytes into items; push each finished
    // item, and a marker for a last byte that finishes nothing.
    hrdp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .push      (q_push),
        .push_item (q_push_item)
    );

    // Hold items so that a stalled result channel does not stop byte intake at once.
    hrdp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .head_item (q_head_item)
    );

    // Apply globals, advance offsets and register the result transaction.
    hrdp_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .pop         (q_pop),
        .head_item   (q_head_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

FILE: rtl/hrdp_front.sv
// Byte assembler: turns descriptor bytes into complete items for the queue.
module hrdp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hrdp_pkg::in_t        s_data,
    input  logic                 q_full,
    output logic                 push,
    output hrdp_pkg::item_t      push_item
);

    localparam logic [2:0] PH_PREFIX   = 3'd0;
    localparam logic [2:0] PH_LONG_LEN = 3'd1;
    localparam logic [2:0] PH_LONG_TAG = 3'd2;
    localparam logic [2:0] PH_DATA     = 3'd3;
    localparam logic [2:0] PH_SKIP     = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  type_reg, type_next;
    logic [7:0]  tag_reg, tag_next;
    logic [7:0]  left_reg, left_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] accum_reg, accum_next;
    logic        done;
    logic        accept;
    logic [7:0]  b;
    logic [7:0]  len;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.desc_byte;

    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        tag_next   = tag_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        accum_next = accum_reg;
        done       = 1'b0;
        len        = hrdp_pkg::short_len(b[1:0]);
        case (phase_reg)
            PH_LONG_LEN: begin
                left_next  = b;
                phase_next = PH_LONG_TAG;
            end
            PH_LONG_TAG: begin
                tag_next   = b;
                accum_next = '0;
                idx_next   = '0;
                if (left_reg == 8'd0) begin
                    done = 1'b1;
                end else begin
                    phase_next = (left_reg > 8'd4) ? PH_SKIP : PH_DATA;
                end
            end
            PH_DATA: begin
                accum_next = accum_reg | (32'(b) << {idx_reg, 3'b000});
                idx_next   = idx_reg + 2'd1;
                left_next  = left_reg - 8'd1;
                done       = (left_reg == 8'd1);
            end
            PH_SKIP: begin
                left_next = left_reg - 8'd1;
                done      = (left_reg == 8'd1);
            end
            default: begin
                type_next  = b[3:2];
                accum_next = '0;
                idx_next   = '0;
                if (b[7:4] == hrdp_pkg::LONG_ITEM_TAG) begin
                    tag_next   = '0;
                    phase_next = PH_LONG_LEN;
                end else begin
                    tag_next  = {4'd0, b[7:4]};
                    left_next = len;
                    if (len == 8'd0) begin
                        done       = 1'b1;
                        phase_next = PH_PREFIX;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
        endcase
        if (done) begin
            phase_next = PH_PREFIX;
        end
    end

    assign push                 = accept && (done || s_data.last_byte);
    assign push_item.has_item   = done;
    assign push_item.item_type  = type_next;
    assign push_item.item_tag   = tag_next;
    assign push_item.item_value = accum_next;
    assign push_item.last       = s_data.last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            type_reg  <= '0;
            tag_reg   <= '0;
            left_reg  <= '0;
            idx_reg   <= '0;
            accum_reg <= '0;
        end else if (accept) begin
            if (s_data.last_byte) begin
                phase_reg <= PH_PREFIX;
                type_reg  <= '0;
                tag_reg   <= '0;
                left_reg  <= '0;
                idx_reg   <= '0;
                accum_reg <= '0;
            end else begin
                phase_reg <= phase_next;
                type_reg  <= type_next;
                tag_reg   <= tag_next;
                left_reg  <= left_next;
                idx_reg   <= idx_next;
                accum_reg <= accum_next;
            end
        end
    end

endmodule

FILE: rtl/hrdp_queue.sv
// Short FIFO of assembled items between the assembler and the executor.
module hrdp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  hrdp_pkg::item_t  push_item,
    output logic             full,
    output logic             not_empty,
    input  logic             pop,
    output hrdp_pkg::item_t  head_item
);

    localparam int unsigned DEPTH = hrdp_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    hrdp_pkg::item_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/hrdp_back.sv
// Item executor: global state, bit offsets and the registered result stage.
module hrdp_back #(
    parameter int unsigned OFFSET_BITS = hrdp_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_not_empty,
    output logic             pop,
    input  hrdp_pkg::item_t  head_item,
    output logic             m_valid,
    input  logic             m_ready,
    output hrdp_pkg::out_t   m_data
);

    localparam int unsigned SUM_W = ((OFFSET_BITS > 24) ? OFFSET_BITS : 24) + 1;
    localparam int unsigned EXT_W = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
    localparam logic [OFFSET_BITS-1:0] OFF_LIMIT = {OFFSET_BITS{1'b1}};

    logic [15:0] page_reg, page_next;
    logic [7:0]  size_reg, size_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  id_reg, id_next;
    logic [31:0] min_reg, min_next;
    logic [31:0] max_reg, max_next;
    logic [OFFSET_BITS-1:0] in_off_reg, in_off_next;
    logic [OFFSET_BITS-1:0] out_off_reg, out_off_next;

    logic                   m_valid_reg;
    hrdp_pkg::out_t         m_data_reg;

    logic [2:0]             ev;
    logic [OFFSET_BITS-1:0] field;
    logic [OFFSET_BITS-1:0] base;
    logic [OFFSET_BITS-1:0] advanced;
    logic [23:0]            product;
    logic [SUM_W-1:0]       sum;
    logic [EXT_W-1:0]       field_ext;
    logic                   emit;
    hrdp_pkg::out_t         result;

    assign pop = q_not_empty && (!m_valid_reg || m_ready);

    // Offset advance shared by input and output fields.
    assign base     = (head_item.item_tag == hrdp_pkg::MAIN_TAG_INPUT) ? in_off_reg
                                                                     : out_off_reg;
    assign product  = 24'(size_reg) * 24'(count_reg);
    assign sum      = SUM_W'(base) + SUM_W'(product);
    assign advanced = (sum > SUM_W'(OFF_LIMIT)) ? OFF_LIMIT : sum[OFFSET_BITS-1:0];

    always_comb begin
        page_next    = page_reg;
        size_next    = size_reg;
        count_next   = count_reg;
        id_next      = id_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        in_off_next  = in_off_reg;
        out_off_next = out_off_reg;
        ev           = hrdp_pkg::EVENT_NONE;
        field        = '0;
        if (head_item.has_item) begin
            case (head_item.item_type)
                hrdp_pkg::TYPE_GLOBAL: begin
                    case (head_item.item_tag)
                        hrdp_pkg::GLOBAL_TAG_PAGE:  page_next = head_item.item_value[15:0];
                        hrdp_pkg::GLOBAL_TAG_MIN:   min_next  = head_item.item_value;
                        hrdp_pkg::GLOBAL_TAG_MAX:   max_next  = head_item.item_value;
                        hrdp_pkg::GLOBAL_TAG_SIZE: begin
                            size_next = (head_item.item_value > 32'd255) ? 8'hFF
                                        : head_item.item_value[7:0];
                        end
                        hrdp_pkg::GLOBAL_TAG_ID: begin
                            id_next      = head_item.item_value[7:0];
                            in_off_next  = '0;
                            out_off_next = '0;
                        end
                        hrdp_pkg::GLOBAL_TAG_COUNT: begin
                            count_next = (head_item.item_value > 32'd65535) ? 16'hFFFF
                                         : head_item.item_value[15:0];
                        end
                        default: ;
                    endcase
                end
                hrdp_pkg::TYPE_LOCAL: begin
                    ev = hrdp_pkg::EVENT_LOCAL;
                end
                hrdp_pkg::TYPE_MAIN: begin
                    if (head_item.item_tag == hrdp_pkg::MAIN_TAG_INPUT) begin
                        if (size_reg != 8'd0) begin
                            field       = in_off_reg;
                            in_off_next = advanced;
                            ev = head_item.item_value[0] ? hrdp_pkg::EVENT_NONE
                                                         : hrdp_pkg::EVENT_INPUT;
                        end
                    end else if (head_item.item_tag == hrdp_pkg::MAIN_TAG_OUTPUT) begin
                        if (size_reg != 8'd0) begin
                            field        = out_off_reg;
                            out_off_next = advanced;
                            ev           = hrdp_pkg::EVENT_OUTPUT;
                        end
                    end else if (head_item.item_tag == hrdp_pkg::MAIN_TAG_END_COL) begin
                        ev = hrdp_pkg::EVENT_END_COL;
                    end
                end
                default: ;
            endcase
        end
    end

    assign field_ext = EXT_W'(field);
    assign emit      = (ev != hrdp_pkg::EVENT_NONE) || head_item.last;

    always_comb begin
        result.event_kind      = ev;
        result.item_tag        = (ev == hrdp_pkg::EVENT_NONE) ? 8'd0 : head_item.item_tag;
        result.item_value      = (ev == hrdp_pkg::EVENT_NONE) ? 32'd0
                                                              : head_item.item_value;
        result.rpt_id          = id_next;
        result.report_size     = size_next;
        result.report_count    = count_next;
        result.field_offset    = (ev == hrdp_pkg::EVENT_NONE) ? 16'd0 : field_ext[15:0];
        result.usage_page      = page_next;
        result.logical_min     = min_next;
        result.logical_max     = max_next;
        result.descriptor_done = head_item.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg    <= '0;
            size_reg    <= '0;
            count_reg   <= '0;
            id_reg      <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
            in_off_reg  <= '0;
            out_off_reg <= '0;
        end else if (pop) begin
            if (head_item.last) begin
                page_reg    <= '0;
                size_reg    <= '0;
                count_reg   <= '0;
                id_reg      <= '0;
                min_reg     <= '0;
                max_reg     <= '0;
                in_off_reg  <= '0;
                out_off_reg <= '0;
            end else begin
                page_reg    <= page_next;
                size_reg    <= size_next;
                count_reg   <= count_next;
                id_reg      <= id_next;
                min_reg     <= min_next;
                max_reg     <= max_next;
                in_off_reg  <= in_off_next;
                out_off_reg <= out_off_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: tb/sv/hrdp_scoreboard_pkg.sv
// Scoreboard class for the HID report descriptor parser: descriptor predictor and result check.
package hrdp_tb_pkg;

    import hrdp_pkg::*;

    class hrdp_scoreboard;

        typedef enum logic [2:0] {
            PH_PREFIX,
            PH_LONG_LEN,
            PH_LONG_TAG,
            PH_DATA,
            PH_SKIP
        } parse_phase_t;

        out_t         expected_events[$];
        int unsigned  mismatches;
        int unsigned  results_seen;

        parse_phase_t parse_phase;
        logic [1:0]   item_kind;
        logic [7:0]   item_tag_r;
        logic [7:0]   remaining;
        logic [7:0]   data_index;
        logic [31:0]  data_value;
        logic [15:0]  page;
        logic [7:0]   size;
        logic [15:0]  count;
        logic [7:0]   rid;
        logic [31:0]  lmin;
        logic [31:0]  lmax;
        logic [15:0]  in_offset;
        logic [15:0]  out_offset;

        function new();
            mismatches   = 0;
            results_seen = 0;
            clear_state();
        endfunction

        function void clear_state();
            parse_phase = PH_PREFIX;
            item_kind   = '0;
            item_tag_r  = '0;
            remaining   = '0;
            data_index  = '0;
            data_value  = '0;
            page        = '0;
            size        = '0;
            count       = '0;
            rid         = '0;
            lmin        = '0;
            lmax        = '0;
            in_offset   = '0;
            out_offset  = '0;
        endfunction

        function int outstanding();
            return expected_events.size();
        endfunction

        // Saturating bit offset step by size times count.
        function logic [15:0] advance_offset(logic [15:0] offset);
            logic [31:0] sum;
            sum = 32'(offset) + 32'(size) * 32'(count);
            return (sum > 32'h0000_FFFF) ? 16'hFFFF : sum[15:0];
        endfunction

        // Apply a finished item to the globals and return its event kind.
        function logic [2:0] retire_item(logic [1:0] typ, logic [7:0] tag, logic [31:0] val,
                                         output logic [15:0] offset);
            offset = '0;
            if (typ == TYPE_GLOBAL) begin
                case (tag)
                    GLOBAL_TAG_PAGE:  page = val[15:0];
                    GLOBAL_TAG_MIN:   lmin = val;
                    GLOBAL_TAG_MAX:   lmax = val;
                    GLOBAL_TAG_SIZE:  size = (val > 32'd255) ? 8'hFF : val[7:0];
                    GLOBAL_TAG_ID: begin
                        rid        = val[7:0];
                        in_offset  = '0;
                        out_offset = '0;
                    end
                    GLOBAL_TAG_COUNT: count = (val > 32'h0000_FFFF) ? 16'hFFFF : val[15:0];
                    default: ;
                endcase
                return EVENT_NONE;
            end
            if (typ == TYPE_LOCAL)
                return EVENT_LOCAL;
            if (typ != TYPE_MAIN)
                return EVENT_NONE;
            if ((tag == MAIN_TAG_INPUT || tag == MAIN_TAG_OUTPUT) && size == 8'd0)
                return EVENT_NONE;
            if (tag == MAIN_TAG_INPUT) begin
                offset    = in_offset;
                in_offset = advance_offset(in_offset);
                return val[0] ? EVENT_NONE : EVENT_INPUT;
            end
            if (tag == MAIN_TAG_OUTPUT) begin
                offset     = out_offset;
                out_offset = advance_offset(out_offset);
                return EVENT_OUTPUT;
            end
            if (tag == MAIN_TAG_END_COL)
                return EVENT_END_COL;
            return EVENT_NONE;
        endfunction

        // Advance the parser by one accepted byte; queue the event it causes, if any.
        function void note_byte(in_t item);
            logic [7:0]  b;
            logic        complete;
            logic [15:0] offset;
            out_t        ev;
            b        = item.desc_byte;
            complete = 1'b0;
            ev       = '0;
            case (parse_phase)
                PH_LONG_LEN: begin
                    remaining   = b;
                    parse_phase = PH_LONG_TAG;
                end
                PH_LONG_TAG: begin
                    item_tag_r = b;
                    data_value = '0;
                    data_index = '0;
                    if (remaining == 8'd0)
                        complete = 1'b1;
                    else
                        parse_phase = (remaining > 8'd4) ? PH_SKIP : PH_DATA;
                end
                PH_DATA: begin
                    data_value = data_value | (32'(b) << {data_index[1:0], 3'b000});
                    data_index = data_index + 8'd1;
                    remaining  = remaining - 8'd1;
                    if (remaining == 8'd0)
                        complete = 1'b1;
                end
                PH_SKIP: begin
                    remaining = remaining - 8'd1;
                    if (remaining == 8'd0)
                        complete = 1'b1;
                end
                default: begin
                    item_kind   = b[3:2];
                    data_value  = '0;
                    data_index  = '0;
                    parse_phase = PH_PREFIX;
                    if (b[7:4] == LONG_ITEM_TAG) begin
                        item_tag_r  = '0;
                        parse_phase = PH_LONG_LEN;
                    end else begin
                        item_tag_r = {4'h0, b[7:4]};
                        remaining  = (b[1:0] == 2'd3) ? 8'd4 : {6'd0, b[1:0]};
                        if (remaining == 8'd0)
                            complete = 1'b1;
                        else
                            parse_phase = PH_DATA;
                    end
                end
            endcase

            ev.event_kind = EVENT_NONE;
            if (complete) begin
                parse_phase   = PH_PREFIX;
                ev.item_tag   = item_tag_r;
                ev.item_value = data_value;
                ev.event_kind = retire_item(item_kind, item_tag_r, data_value, offset);
                ev.field_offset = offset;
            end
            if (ev.event_kind == EVENT_NONE) begin
                if (!item.last_byte)
                    return;
                ev.item_tag     = '0;
                ev.item_value   = '0;
                ev.field_offset = '0;
            end
            ev.rpt_id          = rid;
            ev.report_size     = size;
            ev.report_count    = count;
            ev.usage_page      = page;
            ev.logical_min     = lmin;
            ev.logical_max     = lmax;
            ev.descriptor_done = item.last_byte;
            expected_events.push_back(ev);
            if (item.last_byte)
                clear_state();
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40)
                $display("ERROR: result %0d: %s", results_seen, what);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_result(out_t got);
            out_t want;
            results_seen++;
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = expected_events.pop_front();
            compare_field("event_kind", 32'(got.event_kind), 32'(want.event_kind));
            compare_field("item_tag", 32'(got.item_tag), 32'(want.item_tag));
            compare_field("item_value", got.item_value, want.item_value);
            compare_field("rpt_id", 32'(got.rpt_id), 32'(want.rpt_id));
            compare_field("report_size", 32'(got.report_size), 32'(want.report_size));
            compare_field("report_count", 32'(got.report_count), 32'(want.report_count));
            compare_field("field_offset", 32'(got.field_offset), 32'(want.field_offset));
            compare_field("usage_page", 32'(got.usage_page), 32'(want.usage_page));
            compare_field("logical_min", got.logical_min, want.logical_min);
            compare_field("logical_max", got.logical_max, want.logical_max);
            compare_field("descriptor_done", 32'(got.descriptor_done),
                          32'(want.descriptor_done));
        endtask

    endclass

endpackage

FILE: tb/sv/hid_report_descriptor_parser_test.sv
// Top-level testbench: drives descriptors into the parser and checks every event it emits.
module hid_report_descriptor_parser_test;

    import hrdp_pkg::*;
    import hrdp_tb_pkg::*;

    // Codes the package does not name but the stimulus needs.
    localparam logic [1:0] TYPE_RESERVED       = 2'd3;
    localparam logic [7:0] LOCAL_TAG_USAGE     = 8'd0;
    localparam logic [7:0] MAIN_TAG_COLLECTION = 8'd10;
    localparam logic [7:0] GLOBAL_TAG_UNIT     = 8'd6;

    localparam int unsigned RANDOM_BYTES = 1200;
    localparam int unsigned LONG_HOLD    = 300;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    hrdp_scoreboard sb = new();

    // Pacing controls shared by the driver, the sink and the sequence.
    bit          tx_steady;
    bit          rx_steady;
    int unsigned long_hold_req;
    int unsigned bytes_sent;

    // Bytes of the descriptor being built, sent as one burst by flush_descriptor.
    in_t desc_q[$];

    hid_report_descriptor_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watch both channels at the rising edge. Note the accepted byte before
    // checking the result so a same-edge pair is always handled in that order;
    // with a queue slot and the result register between them, a result never
    // belongs to the byte accepted at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_byte(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // Result sink: per result, hold ready low for a random stall, then wait for
    // the transaction. A long hold request from the sequence is counted out here.
    initial begin : result_sink
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (long_hold_req != 0) begin
                stall         = long_hold_req;
                long_hold_req = 0;
            end else if (rx_steady) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 8);
            end
            @(negedge aclk);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Offer one byte after a random gap and hold it until the block takes it.
    // With no gap, valid stays high and only the payload changes.
    task automatic send_byte(in_t item);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Drop valid, then hold off until every expected event has come back.
    task automatic drain_and_wait();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
    endtask

    task automatic push_byte(logic [7:0] b);
        in_t item;
        item.desc_byte = b;
        item.last_byte = 1'b0;
        desc_q.push_back(item);
    endtask

    // Short item: prefix then 0, 1, 2 or 4 little-endian data bytes.
    task automatic add_short(logic [1:0] typ, logic [7:0] tag, logic [1:0] code,
                             logic [31:0] value);
        int unsigned nbytes;
        nbytes = (code == 2'd3) ? 4 : int'(code);
        push_byte({tag[3:0], typ, code});
        for (int unsigned i = 0; i < nbytes; i++)
            push_byte(value[8*i +: 8]);
    endtask

    // Long item: prefix with the long tag nibble, length, tag, then data. Data
    // past the fourth byte is random filler.
    task automatic add_long(logic [1:0] typ, logic [7:0] tag, logic [7:0] len,
                            logic [31:0] value);
        push_byte({LONG_ITEM_TAG, typ, 2'($urandom_range(0, 3))});
        push_byte(len);
        push_byte(tag);
        for (int unsigned i = 0; i < len; i++)
            push_byte((i < 4) ? value[8*i +: 8] : 8'($urandom));
    endtask

    // Mark the last byte, optionally cutting the tail off so the final item is
    // truncated, then send the whole descriptor.
    task automatic flush_descriptor(int unsigned cut);
        int unsigned stop;
        if (cut >= desc_q.size())
            cut = desc_q.size() - 1;
        stop = desc_q.size() - 1 - cut;
        desc_q[stop].last_byte = 1'b1;
        for (int unsigned i = 0; i <= stop; i++)
            send_byte(desc_q[i]);
        desc_q.delete();
    endtask

    // One well-formed item drawn with weights that favor a live field layout:
    // small sizes and counts so offsets mostly stay below saturation.
    task automatic add_random_item();
        int unsigned pick;
        logic [7:0]  tag;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            add_short(TYPE_GLOBAL, GLOBAL_TAG_PAGE, 2'($urandom_range(0, 3)), $urandom);
        end else if (pick < 20) begin
            if ($urandom_range(0, 7) == 0)
                add_short(TYPE_GLOBAL, GLOBAL_TAG_SIZE, 2'($urandom_range(0, 3)), $urandom);
            else
                add_short(TYPE_GLOBAL, GLOBAL_TAG_SIZE, 2'd1, $urandom_range(0, 16));
        end else if (pick < 28) begin
            if ($urandom_range(0, 7) == 0)
                add_short(TYPE_GLOBAL, GLOBAL_TAG_COUNT, 2'($urandom_range(0, 3)), $urandom);
            else
                add_short(TYPE_GLOBAL, GLOBAL_TAG_COUNT, 2'd1, $urandom_range(0, 12));
        end else if (pick < 32) begin
            add_short(TYPE_GLOBAL, GLOBAL_TAG_ID, 2'd1, $urandom);
        end else if (pick < 38) begin
            tag = $urandom_range(0, 1) ? GLOBAL_TAG_MIN : GLOBAL_TAG_MAX;
            add_short(TYPE_GLOBAL, tag, 2'($urandom_range(0, 3)), $urandom);
        end else if (pick < 56) begin
            // Bit 0 of the value picks data or constant at random.
            add_short(TYPE_MAIN, MAIN_TAG_INPUT, 2'($urandom_range(1, 2)), $urandom);
        end else if (pick < 66) begin
            add_short(TYPE_MAIN, MAIN_TAG_OUTPUT, 2'($urandom_range(0, 2)), $urandom);
        end else if (pick < 72) begin
            add_short(TYPE_MAIN, MAIN_TAG_END_COL, 2'd0, '0);
        end else if (pick < 76) begin
            add_short(TYPE_MAIN, MAIN_TAG_COLLECTION, 2'd1, $urandom_range(0, 6));
        end else if (pick < 88) begin
            add_short(TYPE_LOCAL, 8'($urandom_range(0, 14)), 2'($urandom_range(0, 3)),
                      $urandom);
        end else if (pick < 94) begin
            if ($urandom_range(0, 7) == 0)
                add_long(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom_range(5, 40)),
                         $urandom);
            else
                add_long(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom_range(0, 4)),
                         $urandom);
        end else if (pick < 98) begin
            add_short(2'($urandom_range(0, 3)), 8'($urandom_range(0, 14)),
                      2'($urandom_range(0, 3)), $urandom);
        end else begin
            // Global tags the block ignores.
            tag = $urandom_range(0, 1) ? 8'($urandom_range(3, 6)) : 8'($urandom_range(10, 14));
            add_short(TYPE_GLOBAL, tag, 2'($urandom_range(0, 3)), $urandom);
        end
    endtask

    task automatic random_descriptor();
        int unsigned n_items;
        n_items = $urandom_range(3, 40);
        repeat (n_items) add_random_item();
        // About one in six descriptors has its last one to three bytes cut off.
        flush_descriptor(($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
    endtask

    task automatic noise_descriptor();
        int unsigned n_bytes;
        n_bytes = $urandom_range(4, 60);
        repeat (n_bytes) push_byte(8'($urandom));
        flush_descriptor(0);
    endtask

    task automatic directed_descriptors();
        // Input and output need a nonzero size; start with an input at size zero.
        add_short(TYPE_MAIN, MAIN_TAG_INPUT, 2'd1, 32'h02);
        add_short(TYPE_LOCAL, LOCAL_TAG_USAGE, 2'd1, 32'h30);
        // Four-byte globals: page keeps the low half, size and count saturate.
        add_short(TYPE_GLOBAL, GLOBAL_TAG_PAGE, 2'd3, 32'h1234_FFFF);
        add_short(TYPE_GLOBAL, GLOBAL_TAG_SIZE, 2'd3, 32'h0000_0100);
        add_short(TYPE_GLOBAL, GLOBAL_TAG_COUNT, 2'd3, 32'h0001_0000);
        add_short(TYPE_GLOBAL, GLOBAL_TAG_MIN, 2'd1, 32'h80);
        add_short(TYPE_GLOBAL, GLOBAL_TAG_MAX, 2'd3, 32'hFFFF_FFFF);
        // Offsets jump straight to saturation and stay there.
        add_short(TYPE_MAIN, MAIN_TAG_INPUT, 2'd1, 32'h02);
        add_short(TYPE_MAIN, MAIN_TAG_OUTPUT, 2'd1, 32'h02);
        add_short(TYPE_MAIN, MAIN_TAG_INPUT, 2'd2, 32'h0000_FF02);
        // Report id clears both offsets.
        add_short(TYPE_GLOBAL, GLOBAL_TAG_ID, 2'd2, 32'h0000_AB03);
        add_short(TYPE_GLOBAL, GLOBAL_TAG_SIZE, 2'd1, 32'h08);
        add_short(TYPE_GLOBAL, GLOBAL_TAG_COUNT, 2'd1, 32'h02);
        // Constant input advances silently.
        add_short(TYPE_MAIN, MAIN_TAG_INPUT, 2'd1, 32'h01);
        add_short(TYPE_MAIN, MAIN_TAG_INPUT, 2'd1, 32'h02);
        add_short(TYPE_MAIN, MAIN_TAG_OUTPUT, 2'd0, '0);
        add_short(TYPE_MAIN, MAIN_TAG_COLLECTION, 2'd1, 32'h01);
        add_short(TYPE_MAIN, MAIN_TAG_END_COL, 2'd0, '0);
        // Long items: short data, data over four bytes, empty data, long global.
        add_long(TYPE_LOCAL, 8'h5A, 8'd3, 32'h0033_2211);
        add_long(TYPE_LOCAL, 8'hA5, 8'd6, 32'hDEAD_BEEF);
        add_long(TYPE_MAIN, MAIN_TAG_END_COL, 8'd0, '0);
        add_long(TYPE_GLOBAL, GLOBAL_TAG_MIN, 8'd4, 32'h8000_0001);
        add_short(TYPE_RESERVED, 8'd3, 2'd1, 32'h55);
        add_short(TYPE_GLOBAL, GLOBAL_TAG_UNIT, 2'd1, 32'h11);
        add_short(TYPE_GLOBAL, GLOBAL_TAG_SIZE, 2'd1, '0);
        add_short(TYPE_MAIN, MAIN_TAG_OUTPUT, 2'd1, '0);
        // End inside a four-byte item: the item is dropped.
        add_short(TYPE_GLOBAL, GLOBAL_TAG_MAX, 2'd3, 32'h0102_0304);
        flush_descriptor(2);

        // Last byte completes a local item, on fresh globals.
        add_short(TYPE_LOCAL, LOCAL_TAG_USAGE, 2'd1, 32'h05);
        flush_descriptor(0);

        // Last byte lands on the length byte of a long item.
        add_short(TYPE_GLOBAL, GLOBAL_TAG_PAGE, 2'd1, 32'h01);
        add_long(TYPE_LOCAL, 8'h01, 8'd2, 32'h0000_7788);
        flush_descriptor(3);

        // Last byte is an end collection prefix.
        add_short(TYPE_MAIN, MAIN_TAG_END_COL, 2'd0, '0);
        flush_descriptor(0);
    endtask

    initial begin : sequence_main
        int unsigned random_start;
        int unsigned n_desc;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        long_hold_req = 0;
        bytes_sent    = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed_descriptors();

        random_start = bytes_sent;
        n_desc       = 0;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            // Vary pacing per descriptor; some stretches run with no idling at all.
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            // Stall the sink for a long stretch while bytes keep coming, so the
            // item queue fills and the block drops s_ready.
            if (n_desc == 3 || n_desc == 17) begin
                tx_steady     = 1'b1;
                long_hold_req = LONG_HOLD;
            end
            // Quiesce the input until all expected events have drained.
            if (n_desc == 8 || n_desc == 25)
                drain_and_wait();
            if ($urandom_range(0, 9) == 0)
                noise_descriptor();
            else
                random_descriptor();
            n_desc++;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        // Leave room for any stray late result to show up.
        repeat (16) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
